// ===== rtl/bitmap_page_allocator_defines.svh =====
// Assertion macros shared by the allocator's checker.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define BPA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("bitmap_page_allocator: property failed");

// Concurrent assertion that is also checked during reset.
`define BPA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bitmap_page_allocator: property failed");

`endif

// ===== rtl/bpa_pkg.sv =====
// Package with constants and request/response types of the page allocator.
`default_nettype none
package bpa_pkg;
    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int ADDR_W     = 27;
    localparam int CNT_W      = 16;

    localparam logic       OP_ALLOC    = 1'b0;
    localparam logic       OP_FREE     = 1'b1;
    localparam logic       ST_DONE     = 1'b0;
    localparam logic       ST_REFUSED  = 1'b1;
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_PAGES);

    typedef struct packed {
        logic              operation;
        logic [CNT_W-1:0]  page_count;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] run_address;
        logic [CNT_W-1:0]  free_pages;
    } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/bitmap_page_allocator.sv =====
// Top level of the next-fit bitmap page allocator.
//
// Requests arrive on s_valid/s_ready carrying s_req (operation, page_count,
// free_address); one response per request leaves on m_valid/m_ready as m_rsp.
// The used bitmap holds one bit per 4 KiB page in a 512 x 64 memory.
// A free request goes through S_FREE_RD, S_FREE_WR (for a page under the
// limit) and S_RESP to the response register. An allocate request scans
// the bitmap one page per cycle after reading each word in S_SCAN_RD,
// skips fully used 64-page words whole, then marks the run one word at a
// time in S_MARK_RD and S_MARK_WR; its latency depends on the bitmap contents.
// The block handles one request at a time; s_ready is high only when it is
// idle. The latency is set by the single read port of the bitmap memory and
// the bit-serial run counter.
// After reset the bitmap is swept to all ones (every page used) word by
// word in S_CLEAR, during which no request is accepted; page_limit writes on
// cfg_wr_en are taken at any time.
// A finished response sits in the output register while m_ready is low; the
// next request is accepted meanwhile and its result waits until the output
// register is taken.
`default_nettype none
module bitmap_page_allocator (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire bpa_pkg::req_t            s_req,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output bpa_pkg::rsp_t                 m_rsp,
    input  wire logic                     cfg_wr_en,
    input  wire logic [bpa_pkg::CNT_W-1:0] cfg_wr_data
);
    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_FREE_RD  = 9'b000000100,
        S_FREE_WR  = 9'b000001000,
        S_SCAN_RD  = 9'b000010000,
        S_SCAN_BIT = 9'b000100000,
        S_MARK_RD  = 9'b001000000,
        S_MARK_WR  = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    localparam int CW = bpa_pkg::CNT_W;
    localparam int AW = bpa_pkg::WADDR_W;
    localparam int BW = bpa_pkg::BIT_W;
    localparam int WB = bpa_pkg::WORD_BITS;

    state_t state_reg, state_next;

    // Bitmap memory, one read and one write port, registered read data.
    logic [WB-1:0] mem [bpa_pkg::MAP_WORDS];
    logic [WB-1:0] rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [WB-1:0] mem_wdata;

    logic [CW-1:0] limit_reg;
    logic [CW-1:0] nsi_reg, nsi_next;
    logic [CW-1:0] fcnt_reg, fcnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic          phase_reg, phase_next;
    logic [CW-1:0] run_reg, run_next;
    logic [CW-1:0] first_reg, first_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW:0]   end_reg, end_next;
    logic [bpa_pkg::PAGE_W-1:0] fpage_reg, fpage_next;
    bpa_pkg::rsp_t pend_reg, pend_next;
    bpa_pkg::rsp_t m_rsp_reg, m_rsp_next;
    logic          m_valid_reg, m_valid_next;

    logic [CW-1:0] lim;
    logic [CW-1:0] run_inc;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] found_start;
    logic [CW:0]   word_base, next_base;
    logic [WB-1:0] mask_lo, mask_hi;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // Effective limit never exceeds the size of the bitmap.
    assign lim = (limit_reg > CW'(bpa_pkg::MAX_PAGES)) ? CW'(bpa_pkg::MAX_PAGES) : limit_reg;

    assign run_inc     = run_reg + CW'(1);
    assign idx_inc     = idx_reg + CW'(1);
    assign found_start = (run_reg == '0) ? idx_reg : first_reg;
    assign word_base   = {1'b0, idx_reg[CW-1:BW], {BW{1'b0}}};
    assign next_base   = word_base + (CW+1)'(WB);
    assign mask_lo     = {WB{1'b1}} << idx_reg[BW-1:0];
    assign mask_hi     = (end_reg >= next_base) ? {WB{1'b1}}
                                                : ~({WB{1'b1}} << end_reg[BW-1:0]);

    always_comb begin
        state_next   = state_reg;
        nsi_next     = nsi_reg;
        fcnt_next    = fcnt_reg;
        clr_next     = clr_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        phase_next   = phase_reg;
        run_next     = run_reg;
        first_next   = first_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        fpage_next   = fpage_reg;
        pend_next    = pend_reg;
        m_rsp_next   = m_rsp_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = clr_reg;
        mem_raddr    = idx_reg[CW-2:BW];
        mem_wdata    = {WB{1'b1}};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(bpa_pkg::MAP_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    pend_next.status      = bpa_pkg::ST_REFUSED;
                    pend_next.run_address = '0;
                    pend_next.free_pages  = fcnt_reg;
                    fpage_next = s_req.free_address[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
                    cnt_next   = s_req.page_count;
                    mid_next   = (nsi_reg < lim) ? nsi_reg : lim;
                    idx_next   = (nsi_reg < lim) ? nsi_reg : lim;
                    hi_next    = lim;
                    phase_next = 1'b0;
                    run_next   = '0;
                    if (s_req.operation == bpa_pkg::OP_FREE) begin
                        state_next = S_FREE_RD;
                    end else if (s_req.page_count == '0) begin
                        state_next = S_RESP;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_FREE_RD: begin
                if ({1'b0, fpage_reg} < lim) begin
                    mem_re     = 1'b1;
                    mem_raddr  = fpage_reg[bpa_pkg::PAGE_W-1:BW];
                    state_next = S_FREE_WR;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_FREE_WR: begin
                if (rdata_reg[fpage_reg[BW-1:0]]) begin
                    mem_we    = 1'b1;
                    mem_waddr = fpage_reg[bpa_pkg::PAGE_W-1:BW];
                    mem_wdata = rdata_reg & ~(WB'(1) << fpage_reg[BW-1:0]);
                    fcnt_next = (fcnt_reg == {CW{1'b1}}) ? fcnt_reg : fcnt_reg + CW'(1);
                    pend_next.status     = bpa_pkg::ST_DONE;
                    pend_next.free_pages = (fcnt_reg == {CW{1'b1}}) ? fcnt_reg
                                                                    : fcnt_reg + CW'(1);
                end
                state_next = S_RESP;
            end
            S_SCAN_RD: begin
                if (idx_reg >= hi_reg) begin
                    if (!phase_reg) begin
                        // The upper range is exhausted; wrap to the bottom.
                        phase_next = 1'b1;
                        idx_next   = '0;
                        hi_next    = mid_reg;
                        run_next   = '0;
                    end else begin
                        state_next = S_RESP;
                    end
                end else begin
                    mem_re     = 1'b1;
                    state_next = S_SCAN_BIT;
                end
            end
            S_SCAN_BIT: begin
                if (idx_reg >= hi_reg) begin
                    state_next = S_SCAN_RD;
                end else if (&rdata_reg) begin
                    // Whole word used: no run can pass through it.
                    run_next   = '0;
                    idx_next   = CW'(next_base);
                    state_next = S_SCAN_RD;
                end else if (!rdata_reg[idx_reg[BW-1:0]]) begin
                    if (run_reg == '0) begin
                        first_next = idx_reg;
                    end
                    if (run_inc == cnt_reg) begin
                        start_next = found_start;
                        idx_next   = found_start;
                        end_next   = {1'b0, found_start} + {1'b0, cnt_reg};
                        state_next = S_MARK_RD;
                    end else begin
                        run_next = run_inc;
                        idx_next = idx_inc;
                        if (idx_inc[BW-1:0] == '0) begin
                            state_next = S_SCAN_RD;
                        end
                    end
                end else begin
                    run_next = '0;
                    idx_next = idx_inc;
                    if (idx_inc[BW-1:0] == '0) begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_MARK_RD: begin
                mem_re     = 1'b1;
                state_next = S_MARK_WR;
            end
            S_MARK_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[CW-2:BW];
                mem_wdata = rdata_reg | (mask_lo & mask_hi);
                idx_next  = CW'(next_base);
                if (end_reg <= next_base) begin
                    nsi_next  = (cnt_reg == CW'(1)) ? start_reg : end_reg[CW-1:0];
                    fcnt_next = (fcnt_reg > cnt_reg) ? fcnt_reg - cnt_reg : '0;
                    pend_next.status      = bpa_pkg::ST_DONE;
                    pend_next.run_address = bpa_pkg::ADDR_W'({start_reg,
                                                              {bpa_pkg::PAGE_SHIFT{1'b0}}});
                    pend_next.free_pages  = (fcnt_reg > cnt_reg) ? fcnt_reg - cnt_reg : '0;
                    state_next = S_RESP;
                end else begin
                    state_next = S_MARK_RD;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = pend_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            limit_reg   <= bpa_pkg::LIMIT_RESET;
            nsi_reg     <= '0;
            fcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            nsi_reg     <= nsi_next;
            fcnt_reg    <= fcnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        phase_reg <= phase_next;
        run_reg   <= run_next;
        first_reg <= first_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        fpage_reg <= fpage_next;
        pend_reg  <= pend_next;
        m_rsp_reg <= m_rsp_next;
    end
endmodule
`default_nettype wire

// ===== rtl/bpa_checker.sv =====
// Port-level checker for the page allocator and its bind statement.
`default_nettype none
`include "bitmap_page_allocator_defines.svh"
module bpa_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire bpa_pkg::rsp_t m_rsp
);
    `BPA_ASSERT(a_rsp_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_rsp))
    `BPA_ASSERT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    `BPA_ASSERT(a_refused_no_addr, aclk, aresetn, m_valid && (m_rsp.status == bpa_pkg::ST_REFUSED) |-> m_rsp.run_address == '0)
    `BPA_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid && !s_ready)
endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);
`default_nettype wire

// ===== tb/sv/bitmap_page_allocator_tb.sv =====
// Self-checking testbench of the next-fit bitmap page allocator.
`default_nettype none
module bitmap_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted request or response before the run is
    // declared hung. The slowest allocate scans every page under the limit
    // one per cycle and then marks the run, well below this figure.
    localparam int HANG_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 20;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    bpa_pkg::req_t s_req;
    logic          m_valid;
    logic          m_ready;
    bpa_pkg::rsp_t m_rsp;
    logic          cfg_wr_en;
    logic [bpa_pkg::CNT_W-1:0] cfg_wr_data;

    bitmap_page_allocator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rsp       (m_rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Shadow copy of the allocator state, kept in step with every request
    // that the block accepts.
    bit                        page_busy [bpa_pkg::MAX_PAGES];
    logic [bpa_pkg::CNT_W-1:0] search_idx;
    logic [bpa_pkg::CNT_W-1:0] free_cnt;
    logic [bpa_pkg::CNT_W-1:0] limit_shadow;

    // Responses still owed by the block, oldest first.
    bpa_pkg::rsp_t pending_rsp[$];

    int errors;
    int n_alloc, n_free, n_refused, n_rsp;
    int idle_cycles;
    int send_idle_pct, recv_stall_pct;

    typedef enum logic {ROW_REQUEST, ROW_LIMIT} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        bpa_pkg::req_t             req;
        bit                        typed;
        bpa_pkg::rsp_t             rsp;
        logic [bpa_pkg::CNT_W-1:0] limit;
    } boot_row_t;

    boot_row_t boot_rows[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Searches [lo, hi) for the first stretch of cnt free pages.
    function automatic bit find_free_run(input int lo, input int hi, input int cnt,
                                         output int start);
        int run;
        run = 0;
        start = lo;
        for (int i = lo; i < hi; i++) begin
            if (!page_busy[i]) begin
                if (run == 0) start = i;
                run++;
                if (run == cnt) return 1'b1;
            end else begin
                run = 0;
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the shadow state and returns the response the
    // block must give for it.
    function automatic bpa_pkg::rsp_t apply_page_request(input bpa_pkg::req_t r);
        bpa_pkg::rsp_t o;
        int lim, cnt, mid, start, pg;
        bit found;
        lim = (int'(limit_shadow) < bpa_pkg::MAX_PAGES) ? int'(limit_shadow)
                                                        : bpa_pkg::MAX_PAGES;
        o.status = bpa_pkg::ST_REFUSED;
        o.run_address = '0;
        if (r.operation == bpa_pkg::OP_ALLOC) begin
            cnt = int'(r.page_count);
            found = 1'b0;
            if (cnt != 0) begin
                mid = (int'(search_idx) < lim) ? int'(search_idx) : lim;
                found = find_free_run(mid, lim, cnt, start);
                if (!found) found = find_free_run(0, mid, cnt, start);
            end
            if (found) begin
                for (int j = 0; j < cnt; j++) page_busy[start + j] = 1'b1;
                search_idx = bpa_pkg::CNT_W'((cnt == 1) ? start : start + cnt);
                free_cnt = (int'(free_cnt) > cnt) ? bpa_pkg::CNT_W'(int'(free_cnt) - cnt)
                                                  : '0;
                o.run_address = bpa_pkg::ADDR_W'(longint'(start) << bpa_pkg::PAGE_SHIFT);
                o.status = bpa_pkg::ST_DONE;
            end
        end else begin
            pg = int'(r.free_address >> bpa_pkg::PAGE_SHIFT);
            if (pg < lim && page_busy[pg]) begin
                page_busy[pg] = 1'b0;
                if (free_cnt != '1) free_cnt = free_cnt + 1'b1;
                o.status = bpa_pkg::ST_DONE;
            end
        end
        o.free_pages = free_cnt;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        errors++;
    endtask

    // Presents one request, with a random gap in front of it, and records
    // the expected response at the edge where it is accepted.
    task automatic send_request(input bpa_pkg::req_t r, input bit typed,
                                input bpa_pkg::rsp_t typed_rsp);
        bpa_pkg::rsp_t want;
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = apply_page_request(r);
        if (typed) want = typed_rsp;
        pending_rsp.push_back(want);
        if (r.operation == bpa_pkg::OP_ALLOC) n_alloc++;
        else n_free++;
    endtask

    // Holds the sender back until every owed response has come out, then
    // lets the block settle before anything else happens.
    task automatic drain_requests();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The page limit is only changed while the block has nothing in flight.
    task automatic write_page_limit(input logic [bpa_pkg::CNT_W-1:0] value);
        drain_requests();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_shadow = value;
    endtask

    // Random request shaped for the current limit: mostly frees of pages
    // that exist and small allocations, with some oversized counts, zero
    // counts and addresses past the limit mixed in.
    function automatic bpa_pkg::req_t random_request();
        bpa_pkg::req_t r;
        int lim, pg, pick;
        lim = (int'(limit_shadow) < bpa_pkg::MAX_PAGES) ? int'(limit_shadow)
                                                        : bpa_pkg::MAX_PAGES;
        r.operation = bpa_pkg::OP_ALLOC;
        r.page_count = bpa_pkg::CNT_W'($urandom);
        r.free_address = bpa_pkg::ADDR_W'($urandom);
        if ($urandom_range(99) < 55) begin
            r.operation = bpa_pkg::OP_FREE;
            if (lim > 0 && $urandom_range(9) != 0) pg = $urandom_range(lim - 1);
            else pg = $urandom_range(bpa_pkg::MAX_PAGES - 1);
            r.free_address = {pg[bpa_pkg::PAGE_W-1:0],
                              r.free_address[bpa_pkg::PAGE_SHIFT-1:0]};
        end else begin
            pick = $urandom_range(19);
            if (pick == 0) r.page_count = '0;
            else if (pick == 1) r.page_count = bpa_pkg::CNT_W'(lim + $urandom_range(0, 2));
            else if (pick > 3) r.page_count = bpa_pkg::CNT_W'($urandom_range(1, 6));
        end
        return r;
    endfunction

    function automatic void add_request(input logic op, input int cnt, input int addr,
                                        input bit typed, input bpa_pkg::rsp_t rsp);
        boot_row_t row;
        row.kind = ROW_REQUEST;
        row.req.operation = op;
        row.req.page_count = bpa_pkg::CNT_W'(cnt);
        row.req.free_address = bpa_pkg::ADDR_W'(addr);
        row.typed = typed;
        row.rsp = rsp;
        row.limit = '0;
        boot_rows.push_back(row);
    endfunction

    function automatic void add_limit(input logic [bpa_pkg::CNT_W-1:0] value);
        boot_row_t row;
        row.kind = ROW_LIMIT;
        row.req = '0;
        row.typed = 1'b0;
        row.rsp = '0;
        row.limit = value;
        boot_rows.push_back(row);
    endfunction

    // Result channel: random back-pressure and the in-order check.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        bpa_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response", 0, m_rsp);
            end else begin
                want = pending_rsp.pop_front();
                if (m_rsp.status != want.status)
                    report_mismatch("status", want.status, m_rsp.status);
                if (m_rsp.run_address != want.run_address)
                    report_mismatch("run_address", want.run_address, m_rsp.run_address);
                if (m_rsp.free_pages != want.free_pages)
                    report_mismatch("free_pages", want.free_pages, m_rsp.free_pages);
                if (m_rsp.status == bpa_pkg::ST_REFUSED) n_refused++;
            end
        end
    end

    // Hang detector: counts cycles in which neither channel moves a request
    // or response. The reset sweep of the bitmap is well inside the limit.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_CYCLES) begin
                $display("%0t no progress for %0d cycles, %0d responses owed",
                         $realtime, idle_cycles, pending_rsp.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        bpa_pkg::rsp_t none, rsp;
        int phase_limits [3][4];
        int n_items;

        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        errors = 0;
        n_alloc = 0;
        n_free = 0;
        n_refused = 0;
        n_rsp = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        none = '0;

        // Shadow state right after reset: every page taken, limit at full size.
        for (int i = 0; i < bpa_pkg::MAX_PAGES; i++) page_busy[i] = 1'b1;
        search_idx = '0;
        free_cnt = '0;
        limit_shadow = bpa_pkg::LIMIT_RESET;

        // Directed requests. Right after reset nothing can be allocated, so
        // the first answers are known outright; later rows lean on the
        // shadow state. Included are a zero count, the largest count, a
        // double free, the top page, a search index left past the limit,
        // frees past the limit, a zero limit and a limit above the page
        // count.
        rsp = none; rsp.status = bpa_pkg::ST_REFUSED;
        add_request(bpa_pkg::OP_ALLOC, 1, 0, 1'b1, rsp);
        add_request(bpa_pkg::OP_ALLOC, 0, 0, 1'b1, rsp);
        add_request(bpa_pkg::OP_ALLOC, 16'hFFFF, 0, 1'b1, rsp);
        rsp.status = bpa_pkg::ST_DONE; rsp.free_pages = 1;
        add_request(bpa_pkg::OP_FREE, 0, 27'h0000FFF, 1'b1, rsp);
        rsp.status = bpa_pkg::ST_REFUSED;
        add_request(bpa_pkg::OP_FREE, 0, 0, 1'b1, rsp);
        rsp.status = bpa_pkg::ST_DONE; rsp.free_pages = 2;
        add_request(bpa_pkg::OP_FREE, 16'hFFFF, 27'h7FFFFFF, 1'b1, rsp);
        rsp.free_pages = 3;
        add_request(bpa_pkg::OP_FREE, 0, 27'h7FFE000, 1'b1, rsp);
        // The run ends on the top page, so the next search starts past the
        // limit and must restart from page zero.
        add_request(bpa_pkg::OP_ALLOC, 2, 0, 1'b0, none);
        add_request(bpa_pkg::OP_ALLOC, 1, 0, 1'b0, none);
        add_request(bpa_pkg::OP_FREE, 0, 27'h0001000, 1'b0, none);
        add_request(bpa_pkg::OP_FREE, 0, 27'h0002000, 1'b0, none);
        add_request(bpa_pkg::OP_FREE, 0, 27'h0003000, 1'b0, none);
        add_request(bpa_pkg::OP_ALLOC, 3, 0, 1'b0, none);
        add_limit(16'd64);
        add_request(bpa_pkg::OP_FREE, 0, 27'h0040000, 1'b0, none);
        add_request(bpa_pkg::OP_FREE, 0, 27'h003F000, 1'b0, none);
        add_request(bpa_pkg::OP_ALLOC, 1, 0, 1'b0, none);
        add_limit(16'd0);
        add_request(bpa_pkg::OP_FREE, 0, 27'h0000000, 1'b0, none);
        add_request(bpa_pkg::OP_ALLOC, 1, 0, 1'b0, none);
        add_limit(16'hFFFF);
        add_request(bpa_pkg::OP_FREE, 0, 27'h0005000, 1'b0, none);
        add_request(bpa_pkg::OP_ALLOC, 1, 0, 1'b0, none);
        add_request(bpa_pkg::OP_ALLOC, 1, 0, 1'b0, none);

        // Reset is held from time zero, released on a clock edge like every
        // other input is driven, and never asserted again.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (boot_rows[k]) begin
            if (boot_rows[k].kind == ROW_LIMIT) write_page_limit(boot_rows[k].limit);
            else send_request(boot_rows[k].req, boot_rows[k].typed, boot_rows[k].rsp);
        end

        // Random part in three idling styles: a mostly busy sender against a
        // slow receiver, the reverse, and then no idling at all. Each style
        // walks a few limits; limits from one below the page count upward make
        // the scans long, so those phases get few requests.
        phase_limits = '{'{256, 64, 32768, 1}, '{0, 700, 65535, 128}, '{200, 63, 32767, 512}};
        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 18 : (m == 1) ? 53 : 0;
            recv_stall_pct = (m == 0) ? 53 : (m == 1) ? 18 : 0;
            for (int p = 0; p < 4; p++) begin
                write_page_limit(bpa_pkg::CNT_W'(phase_limits[m][p]));
                n_items = (phase_limits[m][p] >= bpa_pkg::MAX_PAGES - 1) ? 30 : 190;
                for (int k = 0; k < n_items; k++) send_request(random_request(), 1'b0, none);
            end
        end

        drain_requests();

        $display("Covered %0d allocate and %0d free requests, %0d responses, %0d refused,",
                 n_alloc, n_free, n_rsp, n_refused);
        $display("over page limits from zero to above the page count with three idling styles.");
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d responses missing", errors, pending_rsp.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
